>>> hw/rtl/round_robin_thread_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define RRTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RRTS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/rrts_pkg.sv
`default_nettype none

package rrts_pkg;

	localparam int NUM_CPUS    = 16;
	localparam int MAX_THREADS = 64;

	localparam int ID_W      = $clog2(MAX_THREADS);
	localparam int CNT_W     = $clog2(MAX_THREADS + 1);
	localparam int CPU_IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

	localparam int OP_W   = 2;
	localparam int CPU_W  = 4;
	localparam int TID_W  = 6;
	localparam int STAT_W = 2;

	typedef logic [ID_W-1:0]      id_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [CPU_IDX_W-1:0] cpu_idx_t;
	typedef logic [TID_W-1:0]     tid_t;

	typedef enum logic [OP_W-1:0] {
		OP_INIT   = 2'd0,
		OP_CREATE = 2'd1,
		OP_TICK   = 2'd2,
		OP_EXIT   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_NOCPU     = 2'd2
	} status_t;

	typedef struct packed {
		logic valid;
		id_t  cur;
		id_t  idle;
	} cpu_entry_t;

	typedef struct packed {
		logic       en;
		cpu_idx_t   idx;
		cpu_entry_t ent;
	} cpu_wr_t;

	// ring position advance
	function automatic id_t next_pos(input id_t p);
		id_t r;
		if (p == id_t'(MAX_THREADS - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rrts_ram.sv
`default_nettype none

module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/rrts_cpu_tbl.sv
`default_nettype none

module rrts_cpu_tbl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rrts_pkg::cpu_idx_t    rd_idx,
	output rrts_pkg::cpu_entry_t       rd_ent,
	input  wire rrts_pkg::cpu_wr_t     wr
);

	logic          valid_q [rrts_pkg::NUM_CPUS];
	rrts_pkg::id_t cur_q   [rrts_pkg::NUM_CPUS];
	rrts_pkg::id_t idle_q  [rrts_pkg::NUM_CPUS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rrts_pkg::NUM_CPUS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (wr.en) begin
			valid_q[wr.idx] <= wr.ent.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			cur_q[wr.idx]  <= wr.ent.cur;
			idle_q[wr.idx] <= wr.ent.idle;
		end
	end

	always_comb begin
		rd_ent.valid = valid_q[rd_idx];
		rd_ent.cur   = cur_q[rd_idx];
		rd_ent.idle  = idle_q[rd_idx];
	end

endmodule

`default_nettype wire

>>> hw/rtl/round_robin_thread_scheduler.sv
// Round-robin thread scheduler, many CPUs sharing one FIFO ready queue.
// Request channel: opcode and cpu_index are taken at a rising edge where
// start is high and busy is low. busy is high in the cycle after a
// request is taken, while the request sits in the stage register.
// Result channel: thread_id, switched and status appear with done high for
// exactly one cycle; the receiver cannot stall it and must sample it then.
// A request passes the request register, then the result register, which
// drives done and the result.
// A new request is not taken while one sits in the stage register; this
// leaves time for the registered read of the ready-queue RAM at the head
// position, which the decision stage needs before it can update state.
// Per-CPU current/idle ids live in flip-flops with valid bits; the ready
// queue is a RAM that is never cleared, guarded by head/tail/count.
// Reset (arst_n low, asynchronous) empties the queue, marks all CPUs
// uninitialized, restarts id allocation at zero and drops any request in
// flight; no result is produced for it.
`default_nettype none

`include "round_robin_thread_scheduler_defines.svh"

module round_robin_thread_scheduler (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [rrts_pkg::OP_W-1:0]   opcode,
	input  wire logic [rrts_pkg::CPU_W-1:0]  cpu_index,
	output logic                             done,
	output logic [rrts_pkg::TID_W-1:0]       thread_id,
	output logic                             switched,
	output logic [rrts_pkg::STAT_W-1:0]      status
);

	logic                         valid_s1;
	rrts_pkg::op_t                op_s1;
	logic [rrts_pkg::CPU_W-1:0]   cpu_s1;

	rrts_pkg::id_t                head_q, tail_q;
	rrts_pkg::cnt_t               count_q, next_id_q;
	rrts_pkg::id_t                head_d, tail_d;
	rrts_pkg::cnt_t               count_d, next_id_d;

	logic                         done_q;
	rrts_pkg::tid_t               res_id_q, res_id_d;
	logic                         res_sw_q, res_sw_d;
	rrts_pkg::status_t            res_st_q, res_st_d;

	logic                         accept;
	logic                         cpu_ok, exhausted, fifo_empty;
	logic                         is_idle, term, requeue;
	rrts_pkg::id_t                new_id, head_id;
	rrts_pkg::cpu_entry_t         ent;
	rrts_pkg::cpu_wr_t            tbl_wr;
	logic                         ram_we;
	rrts_pkg::id_t                ram_wdata;

	assign accept = start && !busy;
	assign busy   = valid_s1;

	rrts_ram #(
		.WIDTH(rrts_pkg::ID_W),
		.DEPTH(rrts_pkg::MAX_THREADS)
	) u_fifo (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata(ram_wdata),
		.raddr(head_q),
		.rdata(head_id)
	);

	rrts_cpu_tbl u_cpu_tbl (
		.clk   (clk),
		.arst_n(arst_n),
		.rd_idx(rrts_pkg::cpu_idx_t'(cpu_s1)),
		.rd_ent(ent),
		.wr    (tbl_wr)
	);

	assign cpu_ok     = int'(cpu_s1) < rrts_pkg::NUM_CPUS;
	assign exhausted  = next_id_q == rrts_pkg::cnt_t'(rrts_pkg::MAX_THREADS);
	assign fifo_empty = count_q == '0;
	assign new_id     = rrts_pkg::id_t'(next_id_q);
	assign is_idle    = ent.cur == ent.idle;
	assign term       = (op_s1 == rrts_pkg::OP_EXIT) && !is_idle;
	assign requeue    = !term && !is_idle;

	always_comb begin
		head_d        = head_q;
		tail_d        = tail_q;
		count_d       = count_q;
		next_id_d     = next_id_q;
		ram_we        = 1'b0;
		ram_wdata     = new_id;
		tbl_wr.en     = 1'b0;
		tbl_wr.idx    = rrts_pkg::cpu_idx_t'(cpu_s1);
		tbl_wr.ent    = ent;
		res_id_d      = '0;
		res_sw_d      = 1'b0;
		res_st_d      = rrts_pkg::ST_OK;
		case (op_s1)
			rrts_pkg::OP_INIT: begin
				if (!cpu_ok) begin
					res_st_d = rrts_pkg::ST_NOCPU;
				end else if (exhausted) begin
					res_st_d = rrts_pkg::ST_EXHAUSTED;
				end else begin
					next_id_d       = next_id_q + 1'b1;
					tbl_wr.en       = valid_s1;
					tbl_wr.ent.valid = 1'b1;
					tbl_wr.ent.cur  = new_id;
					tbl_wr.ent.idle = new_id;
					res_id_d        = rrts_pkg::tid_t'(new_id);
					res_sw_d        = 1'b1;
				end
			end
			rrts_pkg::OP_CREATE: begin
				if (exhausted) begin
					res_st_d = rrts_pkg::ST_EXHAUSTED;
				end else begin
					next_id_d = next_id_q + 1'b1;
					ram_we    = valid_s1;
					ram_wdata = new_id;
					tail_d    = rrts_pkg::next_pos(tail_q);
					count_d   = count_q + 1'b1;
					res_id_d  = rrts_pkg::tid_t'(new_id);
				end
			end
			default: begin
				if (!cpu_ok || !ent.valid) begin
					res_st_d = rrts_pkg::ST_NOCPU;
				end else if (fifo_empty) begin
					// nothing queued: live thread keeps the cpu, exited one drops to idle
					if (term) begin
						tbl_wr.en      = valid_s1;
						tbl_wr.ent.cur = ent.idle;
						res_id_d       = rrts_pkg::tid_t'(ent.idle);
						res_sw_d       = 1'b1;
					end else begin
						res_id_d = rrts_pkg::tid_t'(ent.cur);
					end
				end else begin
					head_d         = rrts_pkg::next_pos(head_q);
					tbl_wr.en      = valid_s1;
					tbl_wr.ent.cur = head_id;
					res_id_d       = rrts_pkg::tid_t'(head_id);
					res_sw_d       = 1'b1;
					if (requeue) begin
						ram_we    = valid_s1;
						ram_wdata = ent.cur;
						tail_d    = rrts_pkg::next_pos(tail_q);
					end else begin
						count_d = count_q - 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			next_id_q <= '0;
			done_q    <= 1'b0;
		end else begin
			valid_s1 <= accept;
			done_q   <= valid_s1;
			if (valid_s1) begin
				head_q    <= head_d;
				tail_q    <= tail_d;
				count_q   <= count_d;
				next_id_q <= next_id_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= rrts_pkg::op_t'(opcode);
			cpu_s1 <= cpu_index;
		end
		if (valid_s1) begin
			res_id_q <= res_id_d;
			res_sw_q <= res_sw_d;
			res_st_q <= res_st_d;
		end
	end

	assign done      = done_q;
	assign thread_id = res_id_q;
	assign switched  = res_sw_q;
	assign status    = res_st_q;

	`RRTS_ASSERT(a_result_follows, valid_s1 |=> done, "request lost before result")
	`RRTS_ASSERT(a_empty_ring, (count_q == '0) |-> (head_q == tail_q), "empty queue, pointers apart")
	`RRTS_ASSERT(a_ids_monotonic, valid_s1 |=> (next_id_q >= $past(next_id_q)), "id counter went back")
	`RRTS_ASSERT_ALWAYS(a_count_bound, !arst_n || count_q <= rrts_pkg::cnt_t'(rrts_pkg::MAX_THREADS), "queue overfilled")
	`RRTS_ASSERT(a_nocpu_result, (done && status == rrts_pkg::ST_NOCPU) |-> (!switched && thread_id == '0), "bad no-cpu result")

endmodule

`default_nettype wire

>>> bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rrts_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_REQS = 2000;

	typedef enum logic [1:0] {
		THR_READY,
		THR_RUNNING,
		THR_DEAD
	} thr_state_t;

	typedef struct {
		op_t              op;
		logic [CPU_W-1:0] cpu;
		bit               hold;
	} sched_req_t;

	typedef struct {
		tid_t    tid;
		logic    sw;
		status_t st;
	} sched_outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [OP_W-1:0] opcode = '0;
	logic [CPU_W-1:0] cpu_index = '0;
	logic busy;
	logic done;
	logic [TID_W-1:0] thread_id;
	logic switched;
	logic [STAT_W-1:0] status;

	sched_req_t req_queue[$];
	sched_outcome_t due_outcomes[$];
	int errors = 0;
	int cycles = 0;
	int accepted = 0;

	// generator-side view, used only to steer stimulus
	int ids_handed = 0;
	bit cpu_booted[NUM_CPUS];
	logic [CPU_W-1:0] booted_cpus[$];

	// scheduler state as predicted
	bit         run_valid[NUM_CPUS];
	int         run_id[NUM_CPUS];
	int         idle_id[NUM_CPUS];
	thr_state_t thr_state[MAX_THREADS];
	int         ready_ids[$];
	int         next_id = 0;

	round_robin_thread_scheduler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.cpu_index(cpu_index),
		.done(done),
		.thread_id(thread_id),
		.switched(switched),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic sched_outcome_t dispatch(op_t op, logic [CPU_W-1:0] cpu);
		sched_outcome_t r;
		int c;
		int cur;
		int nxt;
		r.tid = '0;
		r.sw = 1'b0;
		r.st = ST_OK;
		c = int'(cpu);
		if (op == OP_INIT || op == OP_CREATE) begin
			if (op == OP_INIT && c >= NUM_CPUS) begin
				r.st = ST_NOCPU;
			end else if (next_id >= MAX_THREADS) begin
				r.st = ST_EXHAUSTED;
			end else begin
				r.tid = tid_t'(next_id);
				if (op == OP_INIT) begin
					thr_state[next_id] = THR_RUNNING;
					run_id[c] = next_id;
					idle_id[c] = next_id;
					run_valid[c] = 1'b1;
					r.sw = 1'b1;
				end else if (ready_ids.size() < MAX_THREADS) begin
					thr_state[next_id] = THR_READY;
					ready_ids.push_back(next_id);
				end
				next_id++;
			end
			return r;
		end
		if (c >= NUM_CPUS || !run_valid[c]) begin
			r.st = ST_NOCPU;
			return r;
		end
		cur = run_id[c];
		if (op == OP_EXIT && cur != idle_id[c])
			thr_state[cur] = THR_DEAD;
		if (thr_state[cur] == THR_RUNNING && cur != idle_id[c] &&
		    ready_ids.size() < MAX_THREADS) begin
			thr_state[cur] = THR_READY;
			ready_ids.push_back(cur);
		end
		if (ready_ids.size() == 0) begin
			if (thr_state[cur] != THR_DEAD) begin
				thr_state[cur] = THR_RUNNING;
				r.tid = tid_t'(cur);
				return r;
			end
			nxt = idle_id[c];
		end else begin
			nxt = ready_ids.pop_front();
		end
		thr_state[nxt] = THR_RUNNING;
		run_id[c] = nxt;
		r.tid = tid_t'(nxt);
		r.sw = (nxt != cur);
		return r;
	endfunction

	task automatic add_req(op_t op, logic [CPU_W-1:0] cpu, bit hold);
		sched_req_t q;
		q.op = op;
		q.cpu = cpu;
		q.hold = hold;
		req_queue.push_back(q);
		if (op == OP_INIT && ids_handed < MAX_THREADS && !cpu_booted[cpu]) begin
			cpu_booted[cpu] = 1'b1;
			booted_cpus.push_back(cpu);
		end
		if (op == OP_INIT || op == OP_CREATE)
			ids_handed++;
	endtask

	// request driver
	always @(posedge clk) begin
		bit presenting;
		bit pause;
		if (arst_n) begin
			presenting = start;
			if (start && !busy) begin
				due_outcomes.push_back(dispatch(op_t'(opcode), cpu_index));
				accepted++;
				presenting = 1'b0;
			end
			pause = (accepted < 700 || accepted >= 1000) && $urandom_range(0, 99) < 37;
			if (!presenting && req_queue.size() != 0 && !pause &&
			    !(req_queue[0].hold && due_outcomes.size() != 0)) begin
				opcode <= req_queue[0].op;
				cpu_index <= req_queue[0].cpu;
				void'(req_queue.pop_front());
				presenting = 1'b1;
			end
			start <= presenting;
		end
	end

	// result monitor
	always @(posedge clk) begin
		sched_outcome_t e;
		if (arst_n && done) begin
			if (due_outcomes.size() == 0) begin
				if (errors < 10)
					$display("unexpected result: tid %0d sw %0d st %0d",
						thread_id, switched, status);
				errors++;
			end else begin
				e = due_outcomes.pop_front();
				if (thread_id !== e.tid || switched !== e.sw || status !== e.st) begin
					if (errors < 10)
						$display("mismatch: exp tid %0d sw %0d st %0d, got tid %0d sw %0d st %0d",
							e.tid, e.sw, e.st, thread_id, switched, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int roll;
		op_t op;
		logic [CPU_W-1:0] c;

		// directed: unbooted cpus, idle fallback, lone thread, re-init
		add_req(OP_TICK, 4'd3, 1'b0);
		add_req(OP_EXIT, 4'd15, 1'b0);
		add_req(OP_INIT, 4'd0, 1'b0);
		add_req(OP_TICK, 4'd0, 1'b0);
		add_req(OP_EXIT, 4'd0, 1'b0);
		add_req(OP_CREATE, 4'd9, 1'b0);
		add_req(OP_TICK, 4'd0, 1'b0);
		add_req(OP_TICK, 4'd0, 1'b0);
		add_req(OP_INIT, 4'd15, 1'b0);
		add_req(OP_CREATE, 4'd6, 1'b0);
		add_req(OP_TICK, 4'd15, 1'b0);
		add_req(OP_TICK, 4'd0, 1'b0);
		add_req(OP_EXIT, 4'd15, 1'b0);
		add_req(OP_CREATE, 4'd0, 1'b0);
		add_req(OP_CREATE, 4'd15, 1'b0);
		add_req(OP_TICK, 4'd0, 1'b0);
		add_req(OP_TICK, 4'd15, 1'b0);
		add_req(OP_EXIT, 4'd0, 1'b0);
		add_req(OP_INIT, 4'd0, 1'b0);
		add_req(OP_TICK, 4'd0, 1'b0);
		add_req(OP_EXIT, 4'd15, 1'b0);
		add_req(OP_TICK, 4'd15, 1'b0);

		for (int n = 0; n < RANDOM_REQS; n++) begin
			roll = $urandom_range(0, 999);
			if (booted_cpus.size() != 0 && $urandom_range(0, 99) < 85)
				c = booted_cpus[$urandom_range(0, booted_cpus.size() - 1)];
			else
				c = CPU_W'($urandom_range(0, NUM_CPUS - 1));
			if (roll < 15)
				op = OP_INIT;
			else if (roll < 40)
				op = OP_CREATE;
			else if (roll < 240)
				op = OP_EXIT;
			else
				op = OP_TICK;
			add_req(op, c, n == 0 || n == 1000);
		end
		// make sure id exhaustion is reached
		while (ids_handed <= MAX_THREADS + 1)
			add_req(OP_CREATE, CPU_W'($urandom_range(0, NUM_CPUS - 1)), 1'b0);
		add_req(OP_INIT, 4'd7, 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (req_queue.size() != 0 || start || due_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> round_robin_thread_scheduler.f
+incdir+hw/rtl
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_ram.sv
hw/rtl/rrts_cpu_tbl.sv
hw/rtl/round_robin_thread_scheduler.sv
bench/testbench.sv
